/* rtl/core/sss_pkg.sv */
// sss_pkg: widths and derived sizes for the sample statistics summary block
// no dependencies; imported by sample_statistics_summary
package sss_pkg;

  // sizing of the run
  localparam int SAMPLE_BITS = 24;
  localparam int COUNT_BITS  = 16;

  // fixed port widths
  localparam int IN_SMP_W  = 24;
  localparam int OUT_CNT_W = 16;
  localparam int STAT_W    = 32;

  // derived datapath widths
  localparam int FRAC_BITS  = 8;
  localparam int SUM_BITS   = SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_BITS    = 2 * SAMPLE_BITS;
  localparam int SUMSQ_BITS = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int VAR_BITS   = 2 * SAMPLE_BITS + 2 * COUNT_BITS;
  localparam int DIV_BITS   = SUM_BITS + FRAC_BITS;
  localparam int ROOT_BITS  = DIV_BITS;
  localparam int STEP_W     = $clog2(DIV_BITS);

  localparam logic [SAMPLE_BITS-1:0] SMP_MAX   = '1;
  localparam logic [COUNT_BITS-1:0]  COUNT_CAP = '1;

endpackage

/* rtl/core/sample_statistics_summary.sv */
// sample_statistics_summary: count, min, max, mean and standard deviation of a run
// depends on sss_pkg for widths and derived sizes
//
//   channel  handshake               payload
//   -------  ----------------------  ------------------------------------------------
//   in       in_valid_i / in_ready_o  sample_i, has_sample_i, last_i
//   out      out_valid_o/ out_ready_i sample_count_o, minimum_o, maximum_o,
//                                     mean_q8_o, stddev_q8_o, overflowed_o
//
// items without last are taken one per cycle while no run is closing or finishing:
// one stage squares the sample, the next folds it into count, min, max, sum and
// sum of squares; a last item closes the run, and the finish works one bit per
// cycle through a shift-add multiplier, a digit-by-digit square root and a
// restoring divider
// reset clears the run to its empty state and drops any pending result
// a result held on out does not block the next run; a second finish waits in
// its last state until the output register is free
module sample_statistics_summary (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [sss_pkg::IN_SMP_W-1:0]     sample_i,
  input  logic                             has_sample_i,
  input  logic                             last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sss_pkg::OUT_CNT_W-1:0]    sample_count_o,
  output logic [sss_pkg::IN_SMP_W-1:0]     minimum_o,
  output logic [sss_pkg::IN_SMP_W-1:0]     maximum_o,
  output logic [sss_pkg::STAT_W-1:0]       mean_q8_o,
  output logic [sss_pkg::STAT_W-1:0]       stddev_q8_o,
  output logic                             overflowed_o
);
  import sss_pkg::*;

  // sequencer states
  localparam logic [2:0] S_ACC  = 3'd0;  // taking samples
  localparam logic [2:0] S_LOAD = 3'd1;  // run closed, set up the multiplier
  localparam logic [2:0] S_MUL  = 3'd2;  // n*sumsq - sum*sum, one bit a cycle
  localparam logic [2:0] S_SQRT = 3'd3;  // integer square root, one digit a cycle
  localparam logic [2:0] S_DIVM = 3'd4;  // mean division
  localparam logic [2:0] S_DIVS = 3'd5;  // deviation division
  localparam logic [2:0] S_OUT  = 3'd6;  // wait for a free output register

  logic [2:0] state_q, state_d;

  // input stage
  logic                   p_act_q, p_act_d;
  logic                   p_last_q, p_last_d;
  logic                   p_has_q, p_has_d;
  logic [SAMPLE_BITS-1:0] p_smp_q, p_smp_d;
  logic [SQ_BITS-1:0]     p_sq_q, p_sq_d;

  // run state
  logic [COUNT_BITS-1:0]  run_count_q, run_count_d;
  logic [SAMPLE_BITS-1:0] run_min_q, run_min_d;
  logic [SAMPLE_BITS-1:0] run_max_q, run_max_d;
  logic [SUM_BITS-1:0]    run_sum_q, run_sum_d;
  logic [SUMSQ_BITS-1:0]  run_sumsq_q, run_sumsq_d;
  logic                   run_ovf_q, run_ovf_d;

  // finish datapath
  logic [STEP_W-1:0]      step_q, step_d;
  logic                   sub_q, sub_d;
  logic [VAR_BITS-1:0]    acc_q, acc_d;
  logic [VAR_BITS-1:0]    mcand_q, mcand_d;
  logic [SUM_BITS-1:0]    mplr_q, mplr_d;
  logic [ROOT_BITS+1:0]   srem_q, srem_d;
  logic [ROOT_BITS-1:0]   root_q, root_d;
  logic [DIV_BITS-1:0]    dvd_q, dvd_d;
  logic [COUNT_BITS-1:0]  drem_q, drem_d;
  logic [STAT_W-1:0]      mean_q, mean_d;
  logic [STAT_W-1:0]      sdev_q, sdev_d;

  // output register
  logic                   o_vld_q, o_vld_d;
  logic [OUT_CNT_W-1:0]   o_cnt_q, o_cnt_d;
  logic [IN_SMP_W-1:0]    o_min_q, o_min_d;
  logic [IN_SMP_W-1:0]    o_max_q, o_max_d;
  logic [STAT_W-1:0]      o_mean_q, o_mean_d;
  logic [STAT_W-1:0]      o_sdev_q, o_sdev_d;
  logic                   o_ovf_q, o_ovf_d;

  logic                   in_fire;
  logic [SAMPLE_BITS-1:0] smp_sat;
  logic                   out_free;

  // square root step
  logic [ROOT_BITS+1:0]   s_cand, s_trial, srem_nx;
  logic                   s_fit;
  logic [ROOT_BITS-1:0]   root_nx;

  // divider step, dividend register doubles as the quotient
  logic [COUNT_BITS:0]    d_cand;
  logic                   d_fit;
  logic [COUNT_BITS-1:0]  drem_nx;
  logic [DIV_BITS-1:0]    dvd_nx;

  // accept only while accumulating and no closing item is in flight
  assign in_ready_o = (state_q == S_ACC) && !(p_act_q && p_last_q);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !o_vld_q || out_ready_i;

  // oversized samples saturate to the top of the sample range
  assign smp_sat = (sample_i > IN_SMP_W'(SMP_MAX)) ? SMP_MAX
                                                   : sample_i[SAMPLE_BITS-1:0];

  assign s_cand  = {srem_q[ROOT_BITS-1:0], acc_q[VAR_BITS-1 -: 2]};
  assign s_trial = {root_q, 2'b01};
  assign s_fit   = (s_cand >= s_trial);
  assign srem_nx = s_fit ? (s_cand - s_trial) : s_cand;
  assign root_nx = {root_q[ROOT_BITS-2:0], s_fit};

  assign d_cand  = {drem_q, dvd_q[DIV_BITS-1]};
  assign d_fit   = (d_cand >= {1'b0, run_count_q});
  assign drem_nx = d_fit ? COUNT_BITS'(d_cand - {1'b0, run_count_q})
                         : d_cand[COUNT_BITS-1:0];
  assign dvd_nx  = {dvd_q[DIV_BITS-2:0], d_fit};

  always_comb begin
    state_d     = state_q;
    p_act_d     = in_fire;
    p_last_d    = p_last_q;
    p_has_d     = p_has_q;
    p_smp_d     = p_smp_q;
    p_sq_d      = p_sq_q;
    run_count_d = run_count_q;
    run_min_d   = run_min_q;
    run_max_d   = run_max_q;
    run_sum_d   = run_sum_q;
    run_sumsq_d = run_sumsq_q;
    run_ovf_d   = run_ovf_q;
    step_d      = step_q;
    sub_d       = sub_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplr_d      = mplr_q;
    srem_d      = srem_q;
    root_d      = root_q;
    dvd_d       = dvd_q;
    drem_d      = drem_q;
    mean_d      = mean_q;
    sdev_d      = sdev_q;
    o_vld_d     = o_vld_q && !out_ready_i;
    o_cnt_d     = o_cnt_q;
    o_min_d     = o_min_q;
    o_max_d     = o_max_q;
    o_mean_d    = o_mean_q;
    o_sdev_d    = o_sdev_q;
    o_ovf_d     = o_ovf_q;

    // square stage
    if (in_fire) begin
      p_last_d = last_i;
      p_has_d  = has_sample_i;
      p_smp_d  = smp_sat;
      p_sq_d   = SQ_BITS'(smp_sat) * SQ_BITS'(smp_sat);
    end

    case (state_q)
      S_ACC: begin
        if (p_act_q) begin
          if (p_has_q) begin
            if (run_count_q == COUNT_CAP) begin
              run_ovf_d = 1'b1;
            end else begin
              run_count_d = run_count_q + 1'b1;
              if (p_smp_q < run_min_q) run_min_d = p_smp_q;
              if (p_smp_q > run_max_q) run_max_d = p_smp_q;
              run_sum_d   = run_sum_q + SUM_BITS'(p_smp_q);
              run_sumsq_d = run_sumsq_q + SUMSQ_BITS'(p_sq_q);
            end
          end
          if (p_last_q) state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (run_count_q == '0) begin
          mean_d  = '0;
          sdev_d  = '0;
          state_d = S_OUT;
        end else begin
          // first pass adds n copies of sumsq
          acc_d   = '0;
          mcand_d = VAR_BITS'(run_sumsq_q);
          mplr_d  = SUM_BITS'(run_count_q);
          sub_d   = 1'b0;
          step_d  = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (mplr_q[0]) begin
          acc_d = sub_q ? (acc_q - mcand_q) : (acc_q + mcand_q);
        end
        mcand_d = mcand_q << 1;
        mplr_d  = mplr_q >> 1;
        step_d  = step_q + 1'b1;
        if (!sub_q && step_q == STEP_W'(COUNT_BITS - 1)) begin
          // second pass takes sum*sum back off
          mcand_d = VAR_BITS'(run_sum_q);
          mplr_d  = run_sum_q;
          sub_d   = 1'b1;
          step_d  = '0;
        end else if (sub_q && step_q == STEP_W'(SUM_BITS - 1)) begin
          srem_d  = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        // radicand is acc shifted up by twice the fraction bits; zeros shift in below
        acc_d  = acc_q << 2;
        srem_d = srem_nx;
        root_d = root_nx;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(ROOT_BITS - 1)) begin
          dvd_d   = {run_sum_q, FRAC_BITS'(0)};
          drem_d  = '0;
          step_d  = '0;
          state_d = S_DIVM;
        end
      end
      S_DIVM: begin
        dvd_d  = dvd_nx;
        drem_d = drem_nx;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_BITS - 1)) begin
          mean_d  = STAT_W'(dvd_nx);
          dvd_d   = root_q;
          drem_d  = '0;
          step_d  = '0;
          state_d = S_DIVS;
        end
      end
      S_DIVS: begin
        dvd_d  = dvd_nx;
        drem_d = drem_nx;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_BITS - 1)) begin
          sdev_d  = STAT_W'(dvd_nx);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          o_vld_d  = 1'b1;
          o_cnt_d  = OUT_CNT_W'(run_count_q);
          // an empty run reports zero, not the all-ones start value
          o_min_d  = (run_count_q == '0) ? '0 : IN_SMP_W'(run_min_q);
          o_max_d  = IN_SMP_W'(run_max_q);
          o_mean_d = mean_q;
          o_sdev_d = sdev_q;
          o_ovf_d  = run_ovf_q;
          // back to the empty run
          run_count_d = '0;
          run_min_d   = SMP_MAX;
          run_max_d   = '0;
          run_sum_d   = '0;
          run_sumsq_d = '0;
          run_ovf_d   = 1'b0;
          state_d     = S_ACC;
        end
      end
      default: begin
        state_d = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      p_act_q     <= 1'b0;
      p_last_q    <= 1'b0;
      run_count_q <= '0;
      run_min_q   <= SMP_MAX;
      run_max_q   <= '0;
      run_sum_q   <= '0;
      run_sumsq_q <= '0;
      run_ovf_q   <= 1'b0;
      step_q      <= '0;
      sub_q       <= 1'b0;
      o_vld_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      p_act_q     <= p_act_d;
      p_last_q    <= p_last_d;
      run_count_q <= run_count_d;
      run_min_q   <= run_min_d;
      run_max_q   <= run_max_d;
      run_sum_q   <= run_sum_d;
      run_sumsq_q <= run_sumsq_d;
      run_ovf_q   <= run_ovf_d;
      step_q      <= step_d;
      sub_q       <= sub_d;
      o_vld_q     <= o_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_has_q  <= p_has_d;
    p_smp_q  <= p_smp_d;
    p_sq_q   <= p_sq_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplr_q   <= mplr_d;
    srem_q   <= srem_d;
    root_q   <= root_d;
    dvd_q    <= dvd_d;
    drem_q   <= drem_d;
    mean_q   <= mean_d;
    sdev_q   <= sdev_d;
    o_cnt_q  <= o_cnt_d;
    o_min_q  <= o_min_d;
    o_max_q  <= o_max_d;
    o_mean_q <= o_mean_d;
    o_sdev_q <= o_sdev_d;
    o_ovf_q  <= o_ovf_d;
  end

  assign out_valid_o    = o_vld_q;
  assign sample_count_o = o_cnt_q;
  assign minimum_o      = o_min_q;
  assign maximum_o      = o_max_q;
  assign mean_q8_o      = o_mean_q;
  assign stddev_q8_o    = o_sdev_q;
  assign overflowed_o   = o_ovf_q;

  // dropped samples only ever happen on a full run
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_ovf_q |-> (run_count_q == COUNT_CAP))
    else $error("overflow flag set on a run that is not full");

  // an empty run reports zeros throughout
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && o_cnt_q == '0) |->
      (o_min_q == '0 && o_mean_q == '0 && o_sdev_q == '0 && !o_ovf_q))
    else $error("empty run gave a nonzero result");

  // floored mean lies between min and max in fixed point with 8 fraction bits
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && o_cnt_q != '0) |->
      (o_min_q <= o_max_q && o_mean_q >= {o_min_q, 8'h00} &&
       o_mean_q <= {o_max_q, 8'h00}))
    else $error("mean outside the sample range");

  // a closing item blocks intake until the run is back in accumulation
  a_close_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_act_q && p_last_q) |=> !in_ready_o)
    else $error("input accepted while a run is being finished");

endmodule
